### rtl/bss_pkg.sv
// shared constants, types and helpers of the background subtraction segmenter
package bss_pkg;

    // frame geometry and fixed point format
    localparam int MAX_ROWS    = 512;
    localparam int MAX_COLS    = 512;
    localparam int FRAC_BITS   = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    // field widths
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int DIM_W   = 10;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W   = $clog2(STORE_DEPTH * 255 + 1);
    localparam int AVG_W   = 16;
    localparam int THR_W   = 8;
    localparam int DIV_W   = SUM_W + FRAC_BITS;
    localparam int REM_W   = CNT_W + 1;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int PROD_W  = 2 * DIM_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS     = 2'd3;

    localparam logic [THR_W-1:0] THR_RESET  = THR_W'(30);
    localparam logic [CNT_W-1:0] MIN_RESET  = CNT_W'(1000);
    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(512);

    // pixel commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               is_foreground;
        logic [ROW_W-1:0]   pix_row;
        logic [COL_W-1:0]   pix_col;
        logic               frame_done;
        logic [CNT_W-1:0]   fg_total;
        logic [AVG_W-1:0]   avg_ch0;
        logic [AVG_W-1:0]   avg_ch1;
        logic [AVG_W-1:0]   avg_ch2;
        logic               avg_valid;
    } res_t;

    // limit a frame dimension to 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    // absolute difference of two channel values
    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W-1:0] r;
        if (a > b)
            r = a - b;
        else
            r = b - a;
        return r;
    endfunction

endpackage

### rtl/bss_if.sv
// stream and configuration interfaces of the segmenter

interface bss_pix_if import bss_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            command;
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;

    modport source (output valid, output command, output ch0, output ch1, output ch2,
                    input ready);
    modport sink   (input valid, input command, input ch0, input ch1, input ch2,
                    output ready);
endinterface

interface bss_res_if import bss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             is_foreground;
    logic [ROW_W-1:0] pix_row;
    logic [COL_W-1:0] pix_col;
    logic             frame_done;
    logic [CNT_W-1:0] fg_total;
    logic [AVG_W-1:0] avg_ch0;
    logic [AVG_W-1:0] avg_ch1;
    logic [AVG_W-1:0] avg_ch2;
    logic             avg_valid;

    modport source (output valid, output is_foreground, output pix_row, output pix_col,
                    output frame_done, output fg_total, output avg_ch0, output avg_ch1,
                    output avg_ch2, output avg_valid, input ready);
    modport sink   (input valid, input is_foreground, input pix_row, input pix_col,
                    input frame_done, input fg_total, input avg_ch0, input avg_ch1,
                    input avg_ch2, input avg_valid, output ready);
endinterface

interface bss_cfg_if import bss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bss_ram.sv
// generic simple dual port ram with registered read
module bss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/background_subtract_segmenter.sv
// load command: taken whenever idle, the pixel is written to the background ram at once
// segment command: ram read at accept, compare in ST_EVAL, then the output register load
// last pixel of a frame with enough foreground: 34 quotient bits in ST_DIVIDE, then the load
// results leave through an output register; one request is in work at a time
// reset: registers to defaults, positions, sums and count to zero, background ram kept
module background_subtract_segmenter import bss_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    bss_pix_if.sink   pix,
    bss_res_if.source res,
    bss_cfg_if.sink   cfg
);

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] min_reg;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;

    // control state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] load_pos_reg;
    logic [ROW_W-1:0]  scan_row_reg;
    logic [COL_W-1:0]  scan_col_reg;
    logic [SUM_W-1:0]  sum_reg [3];
    logic [CNT_W-1:0]  cnt_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              res_valid_reg;

    // payload
    logic [CH_W-1:0]   cur_reg [3];
    logic [DIV_W-1:0]  dvd_reg [3];
    logic [REM_W-1:0]  rem_reg [3];
    logic [CNT_W-1:0]  den_reg;
    res_t              res_reg;
    res_t              res_data_reg;

    // fsm outputs
    logic pix_ready;
    logic out_load_eval;
    logic out_load_emit;
    logic div_load;
    logic div_step;

    logic pix_acc;
    logic slot_free;
    assign pix_acc   = pix.valid & pix_ready;
    assign slot_free = ~res_valid_reg | res.ready;

    // clamped frame size and end positions
    logic [DIM_W-1:0]  rows, cols, rows_m1, cols_m1;
    logic [PROD_W-1:0] frame_pix, last_pos;
    logic              last_row, last_col, is_last;
    assign rows      = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));
    assign cols      = clamp_dim(cols_reg, DIM_W'(MAX_COLS));
    assign rows_m1   = rows - DIM_W'(1);
    assign cols_m1   = cols - DIM_W'(1);
    assign frame_pix = PROD_W'(rows) * PROD_W'(cols);
    assign last_pos  = frame_pix - PROD_W'(1);
    assign last_row  = DIM_W'(scan_row_reg) >= rows_m1;
    assign last_col  = DIM_W'(scan_col_reg) >= cols_m1;
    assign is_last   = last_row & last_col;

    // segment read address
    logic [ROW_W+DIM_W-1:0] seg_prod;
    logic [ROW_W+DIM_W:0]   seg_sum;
    logic [ADDR_W-1:0]      seg_addr;
    assign seg_prod = (ROW_W+DIM_W)'(scan_row_reg) * (ROW_W+DIM_W)'(cols);
    assign seg_sum  = (ROW_W+DIM_W+1)'(seg_prod) + (ROW_W+DIM_W+1)'(scan_col_reg);
    assign seg_addr = seg_sum[ADDR_W-1:0];

    // background store
    logic             ram_we, ram_re;
    logic [PIX_W-1:0] ram_wdata, ram_rdata;
    assign ram_we    = pix_acc & (pix.command == CMD_LOAD);
    assign ram_re    = pix_acc & (pix.command == CMD_SEGMENT);
    assign ram_wdata = {pix.ch2, pix.ch1, pix.ch0};

    bss_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_pos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (seg_addr),
        .rdata (ram_rdata)
    );

    // compare against background and update the running totals
    logic [CH_W-1:0]  bg [3];
    logic             fg;
    logic [SUM_W-1:0] sum_inc [3];
    logic [CNT_W-1:0] cnt_inc;
    logic             avg_ok;
    res_t             res_eval;

    always_comb
    begin
        fg = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            bg[k] = ram_rdata[k*CH_W +: CH_W];
            if (abs_diff(cur_reg[k], bg[k]) > thr_reg)
                fg = 1'b1;
        end
        for (int k = 0; k < 3; k++)
        begin
            sum_inc[k] = fg ? sum_reg[k] + SUM_W'(bg[k]) : sum_reg[k];
        end
        cnt_inc = fg ? cnt_reg + CNT_W'(1) : cnt_reg;
        avg_ok  = cnt_inc > min_reg;

        res_eval               = '0;
        res_eval.is_foreground = fg;
        res_eval.pix_row       = scan_row_reg;
        res_eval.pix_col       = scan_col_reg;
        res_eval.frame_done    = is_last;
        res_eval.fg_total      = is_last ? cnt_inc : '0;
        res_eval.avg_valid     = is_last & avg_ok;
    end

    // restoring divider step, three lanes sharing one count
    logic [REM_W-1:0] trial [3];
    logic             ge [3];
    logic [REM_W-1:0] rem_step [3];
    logic [DIV_W-1:0] dvd_step [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trial[k]    = {rem_reg[k][REM_W-2:0], dvd_reg[k][DIV_W-1]};
            ge[k]       = trial[k] >= REM_W'(den_reg);
            rem_step[k] = ge[k] ? trial[k] - REM_W'(den_reg) : trial[k];
            dvd_step[k] = {dvd_reg[k][DIV_W-2:0], ge[k]};
        end
    end

    // result held through division, averages filled from quotients
    res_t res_final;
    always_comb
    begin
        res_final = res_reg;
        if (res_reg.avg_valid)
        begin
            res_final.avg_ch0 = dvd_reg[0][AVG_W-1:0];
            res_final.avg_ch1 = dvd_reg[1][AVG_W-1:0];
            res_final.avg_ch2 = dvd_reg[2][AVG_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_acc && pix.command == CMD_SEGMENT)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (is_last && avg_ok)
                    state_next = ST_DIVIDE;
                else if (slot_free)
                    state_next = ST_IDLE;
                else
                    state_next = ST_EMIT;
            end
            ST_DIVIDE:
            begin
                if (div_cnt_reg == DCNT_W'(DIV_W - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        pix_ready     = 1'b0;
        out_load_eval = 1'b0;
        out_load_emit = 1'b0;
        div_load      = 1'b0;
        div_step      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pix_ready = 1'b1;
            end
            ST_EVAL:
            begin
                div_load      = is_last & avg_ok;
                out_load_eval = ~(is_last & avg_ok) & slot_free;
            end
            ST_DIVIDE:
            begin
                div_step = 1'b1;
            end
            ST_EMIT:
            begin
                out_load_emit = slot_free;
            end
            default:
            begin
                pix_ready = 1'b0;
            end
        endcase
    end

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            min_reg  <= MIN_RESET;
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DIFF_THRESHOLD: thr_reg  <= cfg.data[THR_W-1:0];
                REG_MIN_PIXELS:     min_reg  <= cfg.data[CNT_W-1:0];
                REG_FRAME_ROWS:     rows_reg <= cfg.data[DIM_W-1:0];
                REG_FRAME_COLS:     cols_reg <= cfg.data[DIM_W-1:0];
                default:            thr_reg  <= thr_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_pos_reg  <= '0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // load position wraps at the last pixel of the frame
            if (ram_we)
            begin
                if (PROD_W'(load_pos_reg) >= last_pos)
                    load_pos_reg <= '0;
                else
                    load_pos_reg <= load_pos_reg + ADDR_W'(1);
            end

            // scan position and frame totals
            if (state_reg == ST_EVAL)
            begin
                if (is_last)
                begin
                    scan_row_reg <= '0;
                    scan_col_reg <= '0;
                    cnt_reg      <= '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k] <= '0;
                    end
                end
                else
                begin
                    if (last_col)
                    begin
                        scan_col_reg <= '0;
                        scan_row_reg <= scan_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        scan_col_reg <= scan_col_reg + COL_W'(1);
                    end
                    cnt_reg <= cnt_inc;
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k] <= sum_inc[k];
                    end
                end
            end

            // divider bit count
            if (div_load)
                div_cnt_reg <= '0;
            else if (div_step)
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);

            // output valid
            if (out_load_eval || out_load_emit)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            cur_reg[0] <= pix.ch0;
            cur_reg[1] <= pix.ch1;
            cur_reg[2] <= pix.ch2;
        end

        if (state_reg == ST_EVAL)
        begin
            res_reg <= res_eval;
        end

        if (div_load)
        begin
            den_reg <= cnt_inc;
            for (int k = 0; k < 3; k++)
            begin
                dvd_reg[k] <= {sum_inc[k], {FRAC_BITS{1'b0}}};
                rem_reg[k] <= '0;
            end
        end
        else if (div_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dvd_reg[k] <= dvd_step[k];
                rem_reg[k] <= rem_step[k];
            end
        end

        if (out_load_eval)
            res_data_reg <= res_eval;
        else if (out_load_emit)
            res_data_reg <= res_final;
    end

    // port drive
    assign pix.ready         = pix_ready;
    assign res.valid         = res_valid_reg;
    assign res.is_foreground = res_data_reg.is_foreground;
    assign res.pix_row       = res_data_reg.pix_row;
    assign res.pix_col       = res_data_reg.pix_col;
    assign res.frame_done    = res_data_reg.frame_done;
    assign res.fg_total      = res_data_reg.fg_total;
    assign res.avg_ch0       = res_data_reg.avg_ch0;
    assign res.avg_ch1       = res_data_reg.avg_ch1;
    assign res.avg_ch2       = res_data_reg.avg_ch2;
    assign res.avg_valid     = res_data_reg.avg_valid;

endmodule
